FILE: rtl/tdpt_pkg.sv
// Shared state and phase codes for the trial-division prime test.
package tdpt_pkg;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // The divisor that the running division uses.
    localparam logic [1:0] PH_THREE = 2'd0;  // divisor 3
    localparam logic [1:0] PH_LOW   = 2'd1;  // divisor i of the pair
    localparam logic [1:0] PH_HIGH  = 2'd2;  // divisor i + 2 of the pair

endpackage

FILE: rtl/trial_division_prime_test.sv
// Trial-division primality test built around one shared restoring divider.
//
// Each beat on the input carries one candidate; the low WIDTH bits are tested and one beat with
// the prime flag comes out. Values below 2, 2, 3 and even values are decided at acceptance
// without the divider. Every other value goes through one restoring divider: first by 3, then
// by i and i + 2 for i = 5, 11, 17, ... The division by i also yields the quotient n / i, and
// the search stops at the first i that exceeds it, or at the first division that leaves no
// remainder. A composite stops at the division that finds its smallest factor. The input is
// ready only while no candidate is being worked on; a finished result may still wait in the
// output register while the next candidate is accepted.
module trial_division_prime_test #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] candidate
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] prime_flag, [7:1] zero
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic [WIDTH-1:0] r_n,     n_n;
    logic [WIDTH-1:0] r_div,   n_div;
    logic [WIDTH-1:0] r_rem,   n_rem;
    logic [WIDTH-1:0] r_quo,   n_quo;
    logic [CW-1:0]    r_cnt,   n_cnt;
    logic             r_res,   n_res;
    logic             r_out_valid, n_out_valid;
    logic             r_out_flag,  n_out_flag;

    logic [WIDTH-1:0] w_cand;
    logic [WIDTH:0]   w_shift;
    logic             w_ge;
    logic [WIDTH:0]   w_diff;
    logic [WIDTH-1:0] w_rem;
    logic [WIDTH-1:0] w_quo;
    logic             w_rem_zero;
    logic             w_out_free;

    assign w_cand     = WIDTH'(i_s_tdata);
    assign o_s_tready = (r_state == tdpt_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_flag};
    assign w_out_free = !r_out_valid || i_m_tready;

    // One step of the restoring divider: the dividend shifts out of the quotient register
    // while quotient bits shift in from the bottom.
    assign w_shift    = {r_rem, r_quo[WIDTH-1]};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_diff     = w_shift - {1'b0, r_div};
    assign w_rem      = w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
    assign w_quo      = {r_quo[WIDTH-2:0], w_ge};
    assign w_rem_zero = (w_rem == '0);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_n         = r_n;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_flag  = r_out_flag;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_n   = w_cand;
                    n_rem = '0;
                    n_quo = w_cand;
                    n_cnt = CW'(WIDTH - 1);
                    priority if (w_cand < WIDTH'(2)) begin
                        n_res   = 1'b0;
                        n_state = tdpt_pkg::ST_DONE;
                    end else if (w_cand == WIDTH'(2) || w_cand == WIDTH'(3)) begin
                        n_res   = 1'b1;
                        n_state = tdpt_pkg::ST_DONE;
                    end else if (!w_cand[0]) begin
                        n_res   = 1'b0;
                        n_state = tdpt_pkg::ST_DONE;
                    end else begin
                        n_div   = WIDTH'(3);
                        n_phase = tdpt_pkg::PH_THREE;
                        n_state = tdpt_pkg::ST_DIV;
                    end
                end
            end
            tdpt_pkg::ST_DIV: begin
                n_rem = w_rem;
                n_quo = w_quo;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    // Division finished: decide, or start the next one.
                    n_rem = '0;
                    n_quo = r_n;
                    n_cnt = CW'(WIDTH - 1);
                    unique case (r_phase)
                        tdpt_pkg::PH_THREE: begin
                            if (w_rem_zero) begin
                                n_res   = 1'b0;
                                n_state = tdpt_pkg::ST_DONE;
                            end else begin
                                n_div   = WIDTH'(5);
                                n_phase = tdpt_pkg::PH_LOW;
                            end
                        end
                        tdpt_pkg::PH_LOW: begin
                            priority if (r_div > w_quo) begin
                                // i * i exceeds n: no divisor left to try.
                                n_res   = 1'b1;
                                n_state = tdpt_pkg::ST_DONE;
                            end else if (w_rem_zero) begin
                                n_res   = 1'b0;
                                n_state = tdpt_pkg::ST_DONE;
                            end else begin
                                n_div   = r_div + WIDTH'(2);
                                n_phase = tdpt_pkg::PH_HIGH;
                            end
                        end
                        default: begin
                            if (w_rem_zero) begin
                                n_res   = 1'b0;
                                n_state = tdpt_pkg::ST_DONE;
                            end else begin
                                n_div   = r_div + WIDTH'(4);
                                n_phase = tdpt_pkg::PH_LOW;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_flag  = r_res;
                    n_state     = tdpt_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase    <= n_phase;
        r_n        <= n_n;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_out_flag <= n_out_flag;
    end

endmodule

FILE: bench/tb_trial_division_prime_test.sv
// Self-checking testbench for the trial-division prime test: directed table, then random beats.
module tb_trial_division_prime_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CAND_W       = 32;
    localparam int     N_RANDOM     = 100;
    localparam int     N_DIRECTED   = 23;
    // The result side holds off once this many results have arrived.
    localparam int     HOLD_AT      = 30;
    localparam int     HOLD_CYCLES  = 2500;
    // Random beats in this window are offered back to back, and their results are taken
    // without a single stall.
    localparam int     QUIET_FROM   = 40;
    localparam int     QUIET_TO     = 65;
    localparam int     TAIL_CYCLES  = 64;
    localparam longint CYCLE_LIMIT  = 4_000_000;

    typedef struct packed {
        logic [31:0] cand;
        bit          typed;   // flag below is already known
        bit          flag;
    } row_t;

    typedef struct packed {
        logic [31:0] cand;
        bit          flag;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;     // [31:0] candidate
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;          // [0] prime_flag, [7:1] zero

    verdict_t    verdicts_due[$];
    int          mismatches = 0;
    int          results_seen = 0;
    longint      cycle_count = 0;

    // Rows with a typed flag can be read off at a glance; the others go to the predictor.
    row_t directed_rows [0:N_DIRECTED-1] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'd2,          1'b1, 1'b1},
        '{32'd3,          1'b1, 1'b1},
        '{32'd4,          1'b1, 1'b0},
        '{32'd24,         1'b1, 1'b0},
        '{32'd5,          1'b0, 1'b0},
        '{32'd7,          1'b0, 1'b0},
        '{32'd9,          1'b1, 1'b0},
        '{32'd25,         1'b1, 1'b0},
        '{32'd35,         1'b1, 1'b0},
        '{32'd49,         1'b1, 1'b0},
        '{32'd121,        1'b0, 1'b0},
        '{32'd143,        1'b0, 1'b0},
        '{32'd169,        1'b0, 1'b0},
        '{32'd65521,      1'b0, 1'b0},
        '{32'd65537,      1'b0, 1'b0},
        '{32'd16777213,   1'b0, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'hFFFF_FFFE,  1'b1, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 1'b0},
        '{32'hAAAA_AAAB,  1'b0, 1'b0},
        '{32'h5555_5555,  1'b0, 1'b0}
    };

    trial_division_prime_test #(
        .WIDTH(CAND_W)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit prime_by_trial(input logic [31:0] raw);
        logic [63:0] n;
        logic [63:0] d;
        n = {32'b0, raw} & ((64'd1 << CAND_W) - 64'd1);
        if (n < 64'd2) return 1'b0;
        if (n == 64'd2 || n == 64'd3) return 1'b1;
        if (!n[0]) return 1'b0;
        if (n % 64'd3 == 64'd0) return 1'b0;
        for (d = 64'd5; d <= n / d; d += 64'd6) begin
            if (n % d == 64'd0 || n % (d + 64'd2) == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Most candidates are small; large ones carry a small factor so that the divider
    // stops early and the run stays short.
    function automatic logic [31:0] pick_candidate();
        int unsigned sel;
        int unsigned p;
        int unsigned v;
        sel = $urandom_range(99);
        if (sel < 30) return $urandom_range(255);
        if (sel < 55) return $urandom_range(65535);
        if (sel < 62) return $urandom_range((1 << 20) - 1);
        if (sel < 82) begin
            v = $urandom;
            if ($urandom_range(1) == 0) v[0] = 1'b0;
            else v = v - v % 3;
            return v;
        end
        p = $urandom_range(1023, 5) | 1;
        v = p * $urandom_range(32'hFFFF_FFFF / p, 1);
        return v;
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance, with tvalid still high.
    task automatic offer_candidate(input logic [31:0] cand, input bit typed, input bit flag,
                                   input bit may_idle);
        verdict_t due;
        if (may_idle) begin
            while ($urandom_range(99) < 7) begin
                i_s_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = cand;
        do @(posedge i_clk); while (!o_s_tready);
        due.cand = cand;
        due.flag = typed ? flag : prime_by_trial(cand);
        verdicts_due.push_back(due);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            offer_candidate(directed_rows[k].cand, directed_rows[k].typed,
                            directed_rows[k].flag, 1'b1);
        end

        // Let everything drain before the random part starts.
        i_s_tvalid = 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);

        for (int k = 0; k < N_RANDOM; k++) begin
            offer_candidate(pick_candidate(), 1'b0, 1'b0, !(k >= QUIET_FROM && k < QUIET_TO));
        end
        i_s_tvalid = 1'b0;

        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, and a stall-free window.
    initial begin
        bit held;
        bit quiet;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            quiet = results_seen >= N_DIRECTED + QUIET_FROM &&
                    results_seen <  N_DIRECTED + QUIET_TO;
            i_m_tready = quiet || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        verdict_t due;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (verdicts_due.size() == 0) begin
                log_mismatch($sformatf("result beat 0x%02h with nothing expected", o_m_tdata));
            end else begin
                due = verdicts_due.pop_front();
                if (o_m_tdata !== {7'b0, due.flag}) begin
                    log_mismatch($sformatf("candidate %0d: expected 0x%02h, got 0x%02h",
                                           due.cand, {7'b0, due.flag}, o_m_tdata));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, verdicts_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

FILE: sim.f
rtl/tdpt_pkg.sv
rtl/trial_division_prime_test.sv
bench/tb_trial_division_prime_test.sv
